### rtl/dsfh_pkg.sv
// Shared types, constants and the half-word packing function for the depth scaler.
package dsfh_pkg;

    localparam int unsigned NumStages = 6;

    localparam logic [31:0] RoundAdd     = 32'h0000_1000;
    localparam logic [23:0] SubBias      = 24'h7F_F000;
    localparam logic [14:0] HalfSat      = 15'h7FFF;
    localparam logic [7:0]  NormLow      = 8'd112;
    localparam logic [7:0]  SatAbove     = 8'd143;
    localparam logic [7:0]  FlushMax     = 8'd101;
    localparam logic [7:0]  SubShiftBase = 8'd125;
    localparam logic [7:0]  ExpAllOnes   = 8'hFF;
    localparam logic [7:0]  ZeroBelowExp = 8'd100;

    // Mantissa of the double constant 0.1, split into a low 32-bit and a high 21-bit part.
    localparam logic [31:0] TenthLo = 32'h9999_999A;
    localparam logic [20:0] TenthHi = 21'h19_9999;

    typedef struct packed {
        logic       sign;
        logic       sat;
        logic       zero;
        logic [7:0] expo;
    } t_side;

    typedef struct packed {
        logic en_a;
        logic en_b;
    } t_mul_ctl;

    function automatic logic [15:0] f_pack_half(input logic [31:0] s);
        logic [31:0] b;
        logic [7:0]  e;
        logic [22:0] m;
        logic [7:0]  sh;
        logic [7:0]  ex;
        logic [23:0] sub;
        logic [23:0] q;
        logic [14:0] mag;
        b   = s + RoundAdd;
        e   = b[30:23];
        m   = b[22:0];
        sh  = SubShiftBase - e;
        ex  = e - NormLow;
        sub = SubBias + {1'b0, m};
        q   = (sub >> sh[4:0]) + 24'd1;
        mag = '0;
        if (e > NormLow) begin
            mag = {ex[4:0], m[22:13]};
        end else if (e > FlushMax) begin
            mag = 15'(q >> 1);
        end
        if (e > SatAbove) begin
            mag = HalfSat;
        end
        return {b[31], mag};
    endfunction

endpackage

### rtl/dsfh_mul.sv
// Two-stage multiplier of a 24-bit mantissa by the 53-bit mantissa of 0.1.
module dsfh_mul (
    input  logic                   i_clk,
    input  dsfh_pkg::t_mul_ctl     i_ctl,
    input  logic [23:0]            i_mant,
    output logic [76:0]            o_prod
);
    import dsfh_pkg::*;

    logic [55:0] r_lo;
    logic [44:0] r_hi;
    logic [76:0] r_prod;
    logic [76:0] n_prod;

    assign n_prod = {r_hi, 32'd0} + {21'd0, r_lo};

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_a) begin
            r_lo <= {32'd0, i_mant} * {24'd0, TenthLo};
            r_hi <= {21'd0, i_mant} * {24'd0, TenthHi};
        end
        if (i_ctl.en_b) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

### rtl/depth_scale_float_to_half.sv
// Top level of the depth scaler: single-precision sample times 0.1, packed to a half word.
// Each request carries one single-precision sample and yields one 16-bit half word; a
// new request is taken every clock unless the output stalls. The samples pass through
// the input register, the two multiplier stages, the double and single rounding stages
// and the output register, and the pipeline stalls stage by stage from the output back.
module depth_scale_float_to_half (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // depth_bits[31:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // half_bits[15:0]
);
    import dsfh_pkg::*;

    logic [NumStages-1:0] r_v;
    logic [NumStages-1:0] w_adv;
    logic [31:0]          r_raw;
    t_side                r_sd1, r_sd2, r_sd3, r_sd4;
    t_side                n_sd1;
    logic [23:0]          w_mant;
    logic [76:0]          w_prod;
    t_mul_ctl             w_ctl;
    logic [52:0]          r_dn;
    logic [52:0]          n_dn;
    logic [7:0]           n_de;
    logic [31:0]          r_s;
    logic [31:0]          n_s;
    logic [15:0]          r_half;
    logic [15:0]          n_half;

    always_comb begin
        w_adv[NumStages-1] = !r_v[NumStages-1] || i_m_axis_tready;
        for (int k = NumStages - 2; k >= 0; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    assign o_s_axis_tready = w_adv[0];
    assign o_m_axis_tvalid = r_v[NumStages-1];
    assign o_m_axis_tdata  = r_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) begin
                r_v[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NumStages; k++) begin
                if (w_adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign w_mant = {r_raw[30:23] != 8'd0, r_raw[22:0]};

    always_comb begin
        n_sd1.sign = r_raw[31];
        n_sd1.sat  = r_raw[30:23] == ExpAllOnes;
        n_sd1.zero = r_raw[30:23] < ZeroBelowExp;
        n_sd1.expo = r_raw[30:23];
    end

    assign w_ctl.en_a = w_adv[1];
    assign w_ctl.en_b = w_adv[2];

    dsfh_mul u_mul (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_mant (w_mant),
        .o_prod (w_prod)
    );

    // Round the exact product to 53 bits, nearest even.
    always_comb begin
        logic [52:0] d;
        logic        g;
        logic        st;
        logic [53:0] dsum;
        if (w_prod[76]) begin
            d  = w_prod[76:24];
            g  = w_prod[23];
            st = |w_prod[22:0];
        end else begin
            d  = w_prod[75:23];
            g  = w_prod[22];
            st = |w_prod[21:0];
        end
        dsum = {1'b0, d} + {53'd0, g & (st | d[0])};
        n_dn = dsum[53] ? {1'b1, 52'd0} : dsum[52:0];
        n_de = r_sd2.expo - 8'd4 + {7'd0, w_prod[76]} + {7'd0, dsum[53]};
    end

    // Round the double mantissa again to 24 bits, nearest even.
    always_comb begin
        logic [23:0] f;
        logic        g;
        logic        st;
        logic [24:0] fsum;
        logic [7:0]  ex;
        f    = r_dn[52:29];
        g    = r_dn[28];
        st   = |r_dn[27:0];
        fsum = {1'b0, f} + {24'd0, g & (st | f[0])};
        ex   = r_sd3.expo + {7'd0, fsum[24]};
        n_s  = {r_sd3.sign, ex, fsum[24] ? 23'd0 : fsum[22:0]};
    end

    always_comb begin
        if (r_sd4.sat) begin
            n_half = {r_sd4.sign, HalfSat};
        end else if (r_sd4.zero) begin
            n_half = {r_sd4.sign, 15'd0};
        end else begin
            n_half = f_pack_half(r_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_raw <= i_s_axis_tdata;
        end
        if (w_adv[1]) begin
            r_sd1 <= n_sd1;
        end
        if (w_adv[2]) begin
            r_sd2 <= r_sd1;
        end
        if (w_adv[3]) begin
            r_sd3 <= '{sign: r_sd2.sign, sat: r_sd2.sat, zero: r_sd2.zero, expo: n_de};
            r_dn  <= n_dn;
        end
        if (w_adv[4]) begin
            r_sd4 <= r_sd3;
            r_s   <= n_s;
        end
        if (w_adv[5]) begin
            r_half <= n_half;
        end
    end

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("Input stalled while the output register is empty.");

    a_sat_magnitude: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[4] && w_adv[5] && r_sd4.sat) |=> (o_m_axis_tdata[14:0] == HalfSat))
        else $error("Infinity or NaN request did not saturate.");

    a_zero_magnitude: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[4] && w_adv[5] && r_sd4.zero && !r_sd4.sat) |=> (o_m_axis_tdata[14:0] == 15'd0))
        else $error("Small request did not flush to zero.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Output valid after reset.");

endmodule

### verif/testbench.sv
// Self-checking testbench for the depth scaler: samples scaled by a tenth and packed to half words.
module testbench;

    import dsfh_pkg::*;

    localparam int unsigned NumRandom  = 750;
    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned MaxReports = 10;

    typedef struct packed {
        logic [31:0] depth;
        logic        known;
        logic [15:0] half;
    } t_row;

    localparam int unsigned NumRows = 19;

    t_row directed_rows [NumRows] = '{
        '{32'h0000_0000, 1'b1, 16'h0000},
        '{32'h8000_0000, 1'b1, 16'h8000},
        '{32'h7F80_0000, 1'b1, 16'h7FFF},
        '{32'hFF80_0000, 1'b1, 16'hFFFF},
        '{32'h7FC0_0000, 1'b1, 16'h7FFF},
        '{32'hFFFF_FFFF, 1'b1, 16'hFFFF},
        '{32'h7F80_0001, 1'b1, 16'h7FFF},
        '{32'h0000_0001, 1'b1, 16'h0000},
        '{32'h807F_FFFF, 1'b1, 16'h8000},
        '{32'h7F7F_FFFF, 1'b1, 16'h7FFF},
        '{32'hFF7F_FFFF, 1'b1, 16'hFFFF},
        '{32'h3F80_0000, 1'b0, 16'h0000},
        '{32'h4120_0000, 1'b0, 16'h0000},
        '{32'h48C7_FE00, 1'b0, 16'h0000},
        '{32'h4980_0000, 1'b0, 16'h0000},
        '{32'h3A83_126F, 1'b0, 16'h0000},
        '{32'h33D6_BF95, 1'b0, 16'h0000},
        '{32'h477F_E000, 1'b0, 16'h0000},
        '{32'hC2C8_0000, 1'b0, 16'h0000}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;   // depth_bits[31:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;        // half_bits[15:0]

    logic [15:0] pending_halves [$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned sink_wait = 0;
    logic        sink_burst = 1'b0;

    depth_scale_float_to_half u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic real pow_two(input int k);
        logic [63:0] bits;
        bits = {1'b0, 11'(k + 1023), 52'b0};
        return $bitstoreal(bits);
    endfunction

    // Exact single to double, a rounded double product, then a second rounding to single.
    function automatic logic [31:0] tenth_single(input logic [31:0] depth);
        real         x;
        real         p;
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] base;
        int          ex;
        int          se;
        int          rsh;
        if (depth[30:23] == 8'd0) begin
            x = real'(depth[22:0]) * pow_two(-149);
        end else begin
            x = real'({1'b1, depth[22:0]}) * pow_two(int'(depth[30:23]) - 150);
        end
        if (depth[31]) begin
            x = -x;
        end
        p = x * 0.1;
        d = $realtobits(p);
        if (d[62:52] == 11'd0) begin
            return {d[63], 31'd0};
        end
        ex  = int'(d[62:52]) - 1023;
        sig = {11'd0, 1'b1, d[51:0]};
        se  = ex + 127;
        if (se >= 1) begin
            rsh  = 29;
            base = 64'(se - 1) << 23;
        end else begin
            rsh  = -(ex + 97);
            base = '0;
        end
        if (rsh >= 54) begin
            q = '0;
        end else begin
            q    = sig >> rsh;
            rem  = sig & ((64'd1 << rsh) - 64'd1);
            half = 64'd1 << (rsh - 1);
            if (rem > half || (rem == half && q[0])) begin
                q = q + 64'd1;
            end
        end
        return {d[63], 31'(base + q)};
    endfunction

    function automatic logic [15:0] half_of_single(input logic [31:0] s);
        logic [31:0] b;
        logic [31:0] e;
        logic [31:0] m;
        logic [31:0] mag;
        b   = s + 32'h0000_1000;
        e   = {24'd0, b[30:23]};
        m   = {9'd0, b[22:0]};
        mag = '0;
        if (e > 32'd112) begin
            mag = (((e - 32'd112) << 10) & 32'h7C00) | (m >> 13);
        end else if (e > 32'd101) begin
            mag = (((32'h007F_F000 + m) >> (32'd125 - e)) + 32'd1) >> 1;
        end
        if (e > 32'd143) begin
            mag = 32'h7FFF;
        end
        return {b[31], mag[14:0]};
    endfunction

    function automatic logic [15:0] scaled_half(input logic [31:0] depth);
        if (depth[30:23] == 8'hFF) begin
            return {depth[31], 15'h7FFF};
        end
        return half_of_single(tenth_single(depth));
    endfunction

    task automatic send_sample(input logic [31:0] depth, input logic known,
                               input logic [15:0] half);
        int unsigned gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= depth;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_halves.push_back(known ? half : scaled_half(depth));
    endtask

    // Ready side: a random wait after each accepted result, with bursts of no waiting.
    always @(posedge i_clk) begin
        if (cycles % 300 == 0) begin
            sink_burst <= ~sink_burst;
        end
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_halves.size() == 0) begin
                mismatches++;
                if (mismatches <= MaxReports) begin
                    $display("unexpected result %h", o_m_axis_tdata);
                end
            end else begin
                if (pending_halves[0] !== o_m_axis_tdata) begin
                    mismatches++;
                    if (mismatches <= MaxReports) begin
                        $display("half_bits mismatch: expected %h, got %h",
                                 pending_halves[0], o_m_axis_tdata);
                    end
                end
                void'(pending_halves.pop_front());
            end
            sink_wait = sink_burst ? 0 : $urandom_range(0, 19);
            i_m_axis_tready <= (sink_wait == 0);
        end else if (sink_wait > 0) begin
            sink_wait--;
            i_m_axis_tready <= (sink_wait == 0);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [31:0] depth;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < NumRows; i++) begin
            send_sample(directed_rows[i].depth, directed_rows[i].known,
                        directed_rows[i].half);
        end
        for (int i = 0; i < NumRandom; i++) begin
            if ($urandom_range(0, 9) < 2) begin
                depth = $urandom;
            end else begin
                depth = {1'($urandom), 8'($urandom_range(95, 160)), 23'($urandom)};
            end
            send_sample(depth, 1'b0, 16'h0000);
        end
        i_s_axis_tvalid <= 1'b0;
        while (pending_halves.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/dsfh_pkg.sv
rtl/dsfh_mul.sv
rtl/depth_scale_float_to_half.sv
verif/testbench.sv
